// ===== design/assert_macros.svh =====
// Assertion helpers. The clock and reset are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sha1_pkg.sv =====
package sha1_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam int         NUM_ROUNDS  = 80;
    localparam int         DIGEST_WORDS = 5;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

endpackage

// ===== design/sha1_in_if.sv =====
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

// ===== design/sha1_out_if.sv =====
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/sha1_round.sv =====
module sha1_round
    import sha1_pkg::*;
(
    input  t_work       i_work,
    input  logic [31:0] i_w,
    input  logic [6:0]  i_rnd,
    output t_work       o_work
);

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] tmp;

    always_comb begin
        if (i_rnd < 7'd20) begin
            f_val = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k_val = K_ROUND0;
        end else if (i_rnd < 7'd40) begin
            f_val = i_work.b ^ i_work.c ^ i_work.d;
            k_val = K_ROUND1;
        end else if (i_rnd < 7'd60) begin
            f_val = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k_val = K_ROUND2;
        end else begin
            f_val = i_work.b ^ i_work.c ^ i_work.d;
            k_val = K_ROUND3;
        end
    end

    assign tmp = {i_work.a[26:0], i_work.a[31:27]} + f_val + i_work.e + k_val + i_w;

    assign o_work.a = tmp;
    assign o_work.b = i_work.a;
    assign o_work.c = {i_work.b[1:0], i_work.b[31:2]};
    assign o_work.d = i_work.c;
    assign o_work.e = i_work.d;

endmodule

// ===== design/sha1_hash_engine.sv =====
// Channel  Dir  Payload                                Accept
// i_in     in   data_byte, byte_valid, end_of_message  valid & ready
// o_out    out  digest_word, word_index, last_word     valid & ready
//
// Bytes: one per cycle while filling; a full 64-byte block then goes through a buffer
// prefetch, 80 rounds at one per cycle and a chaining update.
// End of message: up to 16 padding writes per padded block, one or two
// compressions, then five digest words, one per cycle while o_out.ready is high.
// The 16-word block buffer has one write port and one registered read port.
// Reset is synchronous; the block buffer is not cleared. i_in.ready is low while busy.
module sha1_hash_engine
    import sha1_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    sha1_in_if.sink          i_in,
    sha1_out_if.source       o_out
);

    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        ST_FILL  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state      r_state, n_state;

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;
    logic [31:0] r_w [16];
    logic [31:0] r_h [DIGEST_WORDS];
    t_work       r_work;
    logic [31:0] r_part;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [6:0]  r_rnd;
    logic [3:0]  r_widx;
    logic [2:0]  r_oidx;
    logic        r_first;
    logic        r_len_ok;
    logic        r_eom_pend;
    logic        r_final;

    logic        in_acc;
    logic        out_acc;
    logic [5:0]  fill_nx;
    logic [7:0]  ins_byte;
    logic [31:0] byte_word;
    logic [63:0] len_bits;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  rd_addr;
    logic [31:0] w_sched;
    logic [31:0] w_t;
    t_work       round_out;

    assign i_in.ready        = (r_state == ST_FILL);
    assign in_acc            = i_in.valid && i_in.ready;
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.digest_word = r_h[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd4);
    assign out_acc           = o_out.valid && o_out.ready;

    assign fill_nx   = r_fill + {5'd0, i_in.byte_valid};
    assign ins_byte  = (r_state == ST_FILL) ? i_in.data_byte : PAD_BYTE;
    assign byte_word = r_part | ({24'd0, ins_byte} << {~r_fill[1:0], 3'b000});
    assign len_bits  = {r_count, 3'b000};

    // block buffer write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_fill[5:2];
        mem_wdata = byte_word;
        if (r_state == ST_FILL) begin
            mem_we = in_acc && i_in.byte_valid && (r_fill[1:0] == 2'b11);
        end else if (r_state == ST_PAD) begin
            mem_we    = 1'b1;
            mem_waddr = r_widx;
            if (r_first) begin
                mem_wdata = byte_word;
            end else if (r_len_ok && r_widx == 4'd14) begin
                mem_wdata = len_bits[63:32];
            end else if (r_len_ok && r_widx == 4'd15) begin
                mem_wdata = len_bits[31:0];
            end else begin
                mem_wdata = 32'd0;
            end
        end
    end

    assign rd_addr = (r_state == ST_LOAD) ? 4'd0 : r_rnd[3:0] + 4'd1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // W[t-3] ^ W[t-8] ^ W[t-14] ^ W[t-16]
    assign w_sched = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_t     = (r_rnd < 7'd16) ? r_rdata : {w_sched[30:0], w_sched[31]};

    sha1_round u_round (
        .i_work (r_work),
        .i_w    (w_t),
        .i_rnd  (r_rnd),
        .o_work (round_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (in_acc) begin
                    if (i_in.byte_valid && r_fill == 6'd63) begin
                        n_state = ST_LOAD;
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_widx == 4'd15) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_rnd == 7'(NUM_ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (r_eom_pend) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_OUT: begin
                if (out_acc && r_oidx == 3'd4) begin
                    n_state = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_part     <= '0;
            r_fill     <= '0;
            r_count    <= '0;
            r_rnd      <= '0;
            r_widx     <= '0;
            r_oidx     <= '0;
            r_first    <= 1'b0;
            r_len_ok   <= 1'b0;
            r_eom_pend <= 1'b0;
            r_final    <= 1'b0;
            r_h[0]     <= H0_INIT;
            r_h[1]     <= H1_INIT;
            r_h[2]     <= H2_INIT;
            r_h[3]     <= H3_INIT;
            r_h[4]     <= H4_INIT;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_FILL: begin
                    if (in_acc) begin
                        if (i_in.byte_valid) begin
                            r_fill  <= fill_nx;
                            r_count <= r_count + 61'd1;
                            r_part  <= (r_fill[1:0] == 2'b11) ? 32'd0 : byte_word;
                        end
                        if (i_in.end_of_message) begin
                            r_eom_pend <= 1'b1;
                            r_first    <= 1'b1;
                            r_widx     <= fill_nx[5:2];
                            r_len_ok   <= (fill_nx < 6'd56);
                        end
                    end
                end
                ST_PAD: begin
                    r_part  <= '0;
                    r_first <= 1'b0;
                    r_widx  <= r_widx + 4'd1;
                    if (r_widx == 4'd15) begin
                        r_final  <= r_len_ok;
                        r_len_ok <= 1'b1;
                    end
                end
                ST_LOAD: begin
                    r_rnd <= '0;
                end
                ST_ROUND: begin
                    r_rnd <= r_rnd + 7'd1;
                end
                ST_FOLD: begin
                    r_h[0] <= r_h[0] + r_work.a;
                    r_h[1] <= r_h[1] + r_work.b;
                    r_h[2] <= r_h[2] + r_work.c;
                    r_h[3] <= r_h[3] + r_work.d;
                    r_h[4] <= r_h[4] + r_work.e;
                end
                ST_OUT: begin
                    if (out_acc) begin
                        if (r_oidx == 3'd4) begin
                            r_oidx     <= '0;
                            r_fill     <= '0;
                            r_count    <= '0;
                            r_eom_pend <= 1'b0;
                            r_final    <= 1'b0;
                            r_h[0]     <= H0_INIT;
                            r_h[1]     <= H1_INIT;
                            r_h[2]     <= H2_INIT;
                            r_h[3]     <= H3_INIT;
                            r_h[4]     <= H4_INIT;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_work <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
        end else if (r_state == ST_ROUND) begin
            r_work <= round_out;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_t;
        end
    end

    `ASSERT_ALWAYS(a_no_overlap, !(i_in.ready && o_out.valid), "input and output both open")
    `ASSERT_ALWAYS(a_rnd_range, r_rnd <= 7'(NUM_ROUNDS), "round counter out of range")
    `ASSERT_NEXT(a_last_to_fill, out_acc && o_out.last_word, r_state == ST_FILL && r_h[0] == H0_INIT, "digest end did not restart")
    `ASSERT_NEXT(a_pad_to_load, r_state == ST_PAD && r_widx == 4'd15, r_state == ST_LOAD, "full padded block not compressed")
    `ASSERT_NEXT(a_fold_out, r_state == ST_FOLD && r_final, r_state == ST_OUT && r_oidx == 3'd0, "final block did not emit")

endmodule

// ===== verif/sha1_digest_checker.sv =====
module sha1_digest_checker
    import sha1_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha1_in_if   i_in_mon,
    sha1_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_item;

    logic [31:0]  chain [DIGEST_WORDS];
    logic [7:0]   block_buf [64];
    int           fill;
    logic [60:0]  msg_bytes;
    t_digest_item digest_due [$];
    int           fails = 0;

    function automatic logic [31:0] rol(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void start_message();
        chain[0]  = H0_INIT;
        chain[1]  = H1_INIT;
        chain[2]  = H2_INIT;
        chain[3]  = H3_INIT;
        chain[4]  = H4_INIT;
        fill      = 0;
        msg_bytes = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [NUM_ROUNDS];
        logic [31:0] a, b, c, d, e, f, k, t;
        int          r;
        for (r = 0; r < 16; r++) begin
            w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
        end
        for (r = 16; r < NUM_ROUNDS; r++) begin
            w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < NUM_ROUNDS; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = rol(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        block_buf[fill] = v;
        fill++;
        if (fill == 64) begin
            sha1_compress();
            fill = 0;
        end
    endfunction

    // pad, append bit length, compress, queue the five digest words
    function automatic void close_message();
        logic [63:0]  bit_len;
        t_digest_item item;
        int           i;
        bit_len = {msg_bytes, 3'b000};
        absorb_byte(PAD_BYTE);
        while (fill != 56) begin
            absorb_byte(8'h00);
        end
        for (i = 0; i < 8; i++) begin
            block_buf[56+i] = bit_len[63-8*i -: 8];
        end
        sha1_compress();
        for (i = 0; i < DIGEST_WORDS; i++) begin
            item.digest_word = chain[i];
            item.word_index  = 3'(i);
            item.last_word   = (i == DIGEST_WORDS - 1);
            digest_due = {digest_due, item};
        end
        start_message();
    endfunction

    always @(posedge i_clk) begin
        t_digest_item got, want;
        if (!i_rst_n) begin
            start_message();
            digest_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.digest_word = i_out_mon.digest_word;
                got.word_index  = i_out_mon.word_index;
                got.last_word   = i_out_mon.last_word;
                if (digest_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected digest item, expected none, got word %h index %0d last %b",
                             $time, got.digest_word, got.word_index, got.last_word);
                end else begin
                    want = digest_due.pop_front();
                    if (got.digest_word !== want.digest_word) begin
                        fails++;
                        $display("%0t: digest_word mismatch, expected %h, got %h",
                                 $time, want.digest_word, got.digest_word);
                    end
                    if (got.word_index !== want.word_index) begin
                        fails++;
                        $display("%0t: word_index mismatch, expected %0d, got %0d",
                                 $time, want.word_index, got.word_index);
                    end
                    if (got.last_word !== want.last_word) begin
                        fails++;
                        $display("%0t: last_word mismatch, expected %b, got %b",
                                 $time, want.last_word, got.last_word);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.byte_valid) begin
                    absorb_byte(i_in_mon.data_byte);
                    msg_bytes = msg_bytes + 61'd1;
                end
                if (i_in_mon.end_of_message) begin
                    close_message();
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= digest_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   words_pending;
    bit   calm;
    bit   gappy;
    int   counted_items;
    int   messages;
    int   len;

    sha1_in_if  in_ch ();
    sha1_out_if out_ch ();

    sha1_hash_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sha1_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("sha1_hash_engine verification failed");
        $finish;
    end

    // receiver stalls
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [7:0] data, input logic bv, input logic eom);
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= data;
        in_ch.byte_valid     <= bv;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        if (bv || eom) counted_items++;
        if (eom) messages++;
    endtask

    // random bytes with stray idle items; last byte optionally rides on the closing item
    task automatic send_message(input int n, input bit byte_on_end);
        int   i;
        logic closing;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            closing = (i == n - 1) && byte_on_end;
            send_item(8'($urandom_range(0, 255)), 1'b1, closing);
        end
        if (!(n > 0 && byte_on_end)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= 8'h00;
        in_ch.byte_valid     <= 1'b0;
        in_ch.end_of_message <= 1'b0;
        i_rst_n              <= 1'b0;
        calm          = 1'b0;
        gappy         = 1'b0;
        counted_items = 0;
        messages      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, idle items, byte on the closing item, extreme bytes
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(PAD_BYTE, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        drain();

        // padding spills into a second block, then an exact full block
        gappy = 1'b1;
        send_message(56 + $urandom_range(0, 7), 1'($urandom_range(0, 1)));
        send_message(64, 1'($urandom_range(0, 1)));

        while (counted_items < 180) begin
            gappy = ($urandom_range(0, 3) != 0);
            if (counted_items >= 150) calm = 1'b1;
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 6))
                    0: len = 55;
                    1: len = 56;
                    2: len = 63;
                    3: len = 64;
                    4: len = 65;
                    5: len = 119;
                    default: len = 120;
                endcase
            end else begin
                len = $urandom_range(0, 20);
            end
            send_message(len, (len > 0) && ($urandom_range(0, 1) == 1));
            if ($urandom_range(0, 4) == 0) drain();
        end

        in_ch.valid <= 1'b0;
        drain();
        repeat (200) @(posedge i_clk);

        $display("Ran %0d messages (%0d digest words) over %0d data/close items,",
                 messages, messages * DIGEST_WORDS, counted_items);
        $display("including empty input, padding spill and exact block boundaries.");
        if (fail_count == 0) begin
            $display("sha1_hash_engine verification clean");
        end else begin
            $display("sha1_hash_engine verification failed");
        end
        $finish;
    end

endmodule

// ===== sha1_hash_engine.f =====
+incdir+design
design/sha1_pkg.sv
design/sha1_in_if.sv
design/sha1_out_if.sv
design/sha1_round.sv
design/sha1_hash_engine.sv
verif/sha1_digest_checker.sv
verif/testbench.sv
